FILE: hw/rtl/sobm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sobm_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 24;
  localparam int CFG_WW     = 12;
  localparam int CFG_HW     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SQRT_STEPS = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_WW-1:0] RST_WIDTH  = 12'd640;
  localparam logic [CFG_HW-1:0] RST_HEIGHT = 13'd480;
  localparam logic [7:0]        SAT_VALUE  = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_GRAD,
    ST_SQRT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic grad;
    logic sqrt_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic direct;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sobel_edge_magnitude_rgb_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sobel edge magnitude on an RGB raster stream. Pixels (tuser = 0) enter in raster
// order; a result for pixel p appears once pixel p + width + 1 has entered, and
// flush items (tuser = 1) drain the tail after a full frame. Interior channels give
// floor(sqrt(Gx^2 + Gy^2)) clipped to 255, border pixels pass through; tlast marks
// the last pixel of a frame. One item at a time: an item with no result is captured
// and stepped, a border or flush result is then emitted, and an interior pixel first
// runs the gradient and the 8-step square root in each channel lane; a waiting
// result delays the next item only while unread.
// Writing either size register restarts the frame.
module sobel_edge_magnitude_rgb_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // pixel_red, pixel_green, pixel_blue
  input  wire logic        in_tuser,  // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // edge_red, edge_green, edge_blue
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [sobm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sobm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sobm_pkg::*;

  cmd_t             cmd;
  status_t          sts;
  logic [PIX_W-1:0] res_px;

  assign cfg_ready = 1'b1;

  sobm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .cmd(cmd)
  );

  sobm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_kind(in_tuser),
    .in_pixel({in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]}),
    .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .cmd(cmd), .sts(sts), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_pixel(res_px), .out_last(out_tlast)
  );

  // internal order is red high; port order is red low
  assign out_tdata = {res_px[7:0], res_px[15:8], res_px[23:16]};
endmodule
`default_nettype wire

FILE: hw/rtl/sobm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sobm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/sobm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sobm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire sobm_pkg::status_t sts,
  output sobm_pkg::cmd_t        cmd
);
  import sobm_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (!sts.produce) state_nxt = ST_IDLE;
        else if (sts.direct) state_nxt = ST_EMIT;
        else state_nxt = ST_GRAD;
      end
      ST_GRAD: begin
        cmd.grad  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 3'd1;
        if (cnt_r == 3'(SQRT_STEPS - 1)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/sobm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module sobm_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_kind,
  input  wire logic [sobm_pkg::PIX_W-1:0]   in_pixel,
  input  wire logic                         cfg_we,
  input  wire logic [sobm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [sobm_pkg::CFG_DATA_W-1:0] cfg_val,
  input  wire sobm_pkg::cmd_t               cmd,
  output sobm_pkg::status_t                 sts,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [sobm_pkg::PIX_W-1:0]        out_pixel,
  output logic                              out_last
);
  import sobm_pkg::*;

  // configuration and positions
  logic [CFG_WW-1:0] width_r;
  logic [CFG_HW-1:0] height_r;
  logic [COL_W-1:0]  in_col_r, out_col_r;
  logic [ROW_W-1:0]  in_row_r, out_row_r;
  logic [12:0]       pend_r;
  logic              kind_r;
  logic [PIX_W-1:0]  px_r;
  logic [PIX_W-1:0]  win_r [9];
  logic              direct_r, last_r;
  logic [PIX_W-1:0]  direct_px_r;

  logic [PIX_W-1:0]  up_rd, mid_rd;
  logic [COL_W-1:0]  rd_addr;

  // effective sizes, clipped to the legal range
  logic [12:0] w_eff;
  logic [13:0] h_eff;
  always_comb begin
    if (width_r < CFG_WW'(3)) w_eff = 13'd3;
    else if (width_r > CFG_WW'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
    else w_eff = {1'b0, width_r};
    if (height_r < CFG_HW'(3)) h_eff = 14'd3;
    else if (height_r > CFG_HW'(MAX_HEIGHT)) h_eff = 14'(MAX_HEIGHT);
    else h_eff = {1'b0, height_r};
  end

  assign rd_addr = in_kind ? out_col_r : in_col_r;

  sobm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .wr_en(cmd.step && !kind_r), .wr_addr(in_col_r), .wr_data(mid_rd),
    .rd_en(cmd.capture), .rd_addr(rd_addr), .rd_data(up_rd)
  );
  sobm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .wr_en(cmd.step && !kind_r), .wr_addr(in_col_r), .wr_data(px_r),
    .rd_en(cmd.capture), .rd_addr(rd_addr), .rd_data(mid_rd)
  );

  // step decisions
  logic             at_start, restart, produce, border, lastpos;
  logic [12:0]      pend_eff;
  logic [COL_W-1:0] ocol;
  logic [ROW_W-1:0] orow;
  logic [12:0]      ocol_p1, icol_p1;
  logic [13:0]      orow_p1, irow_p1;
  always_comb begin
    at_start = (in_row_r == '0) && (in_col_r == '0);
    restart  = !kind_r && at_start && (pend_r < w_eff + 13'd1);
    pend_eff = restart ? 13'd0 : pend_r;
    ocol     = restart ? '0 : out_col_r;
    orow     = restart ? '0 : out_row_r;
    if (kind_r) produce = at_start && (pend_r != 13'd0);
    else produce = (pend_eff >= w_eff + 13'd1);
    ocol_p1  = 13'(ocol) + 13'd1;
    orow_p1  = 14'(orow) + 14'd1;
    icol_p1  = 13'(in_col_r) + 13'd1;
    irow_p1  = 14'(in_row_r) + 14'd1;
    border   = (orow == '0) || (orow_p1 >= h_eff) || (ocol == '0) || (ocol_p1 >= w_eff);
    lastpos  = (orow_p1 == h_eff) && (ocol_p1 == w_eff);
  end

  // gradients and squared magnitude per channel
  logic [21:0] mag2 [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [9:0]         pa, na, pb, nb;
      logic signed [10:0] gx, gy;
      logic signed [21:0] sx, sy;
      logic [7:0]         p [9];
      for (int i = 0; i < 9; i++) p[i] = win_r[i][(16 - 8*k) +: 8];
      pa = 10'(p[2]) + {1'b0, p[5], 1'b0} + 10'(p[8]);
      na = 10'(p[0]) + {1'b0, p[3], 1'b0} + 10'(p[6]);
      pb = 10'(p[6]) + {1'b0, p[7], 1'b0} + 10'(p[8]);
      nb = 10'(p[0]) + {1'b0, p[1], 1'b0} + 10'(p[2]);
      gx = $signed({1'b0, pa}) - $signed({1'b0, na});
      gy = $signed({1'b0, pb}) - $signed({1'b0, nb});
      // squares need the full 22-bit width
      sx = 22'(gx);
      sy = 22'(gy);
      mag2[k] = $unsigned(sx * sx) + $unsigned(sy * sy);
    end
  end

  // square root lanes, two bits of radicand per step
  logic [15:0] rad_r  [3];
  logic [9:0]  rem_r  [3];
  logic [7:0]  root_r [3];
  logic        sat_r  [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.grad) begin
        rad_r[k]  <= mag2[k][15:0];
        sat_r[k]  <= (mag2[k][21:16] != '0);
        rem_r[k]  <= '0;
        root_r[k] <= '0;
      end else if (cmd.sqrt_step) begin
        logic [9:0] rem_t, trial;
        rem_t = {rem_r[k][7:0], rad_r[k][15:14]};
        trial = {root_r[k], 2'b01};
        rad_r[k] <= {rad_r[k][13:0], 2'b00};
        if (rem_t >= trial) begin
          rem_r[k]  <= rem_t - trial;
          root_r[k] <= {root_r[k][6:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_t;
          root_r[k] <= {root_r[k][6:0], 1'b0};
        end
      end
    end
  end

  // payload latches
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      px_r   <= in_pixel;
    end
    if (cmd.step) begin
      direct_r <= kind_r || border;
      last_r   <= lastpos;
      if (kind_r) direct_px_r <= (orow_p1 >= h_eff) ? mid_rd : win_r[5];
      else direct_px_r <= win_r[5];
    end
  end

  // control state: config, positions, window, result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= RST_WIDTH;
      height_r   <= RST_HEIGHT;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      pend_r     <= '0;
      out_tvalid <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      if (cfg_we && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT)) begin
        if (cfg_idx == REG_FRAME_WIDTH) width_r <= cfg_val[CFG_WW-1:0];
        else height_r <= cfg_val;
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        pend_r    <= '0;
      end else if (cmd.step) begin
        if (produce) begin
          if (ocol_p1 >= w_eff) begin
            out_col_r <= '0;
            out_row_r <= (orow_p1 >= h_eff) ? '0 : orow_p1[ROW_W-1:0];
          end else begin
            out_col_r <= ocol_p1[COL_W-1:0];
            out_row_r <= orow;
          end
        end else begin
          out_col_r <= ocol;
          out_row_r <= orow;
        end
        if (kind_r) begin
          pend_r <= pend_r - 13'(produce);
        end else begin
          pend_r <= pend_eff + 13'd1 - 13'(produce);
          win_r[0] <= win_r[1]; win_r[1] <= win_r[2]; win_r[2] <= up_rd;
          win_r[3] <= win_r[4]; win_r[4] <= win_r[5]; win_r[5] <= mid_rd;
          win_r[6] <= win_r[7]; win_r[7] <= win_r[8]; win_r[8] <= px_r;
          if (icol_p1 >= w_eff) begin
            in_col_r <= '0;
            in_row_r <= (irow_p1 >= h_eff) ? '0 : irow_p1[ROW_W-1:0];
          end else begin
            in_col_r <= icol_p1[COL_W-1:0];
          end
        end
      end
      if (cmd.emit) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last <= last_r;
      if (direct_r) out_pixel <= direct_px_r;
      else out_pixel <= {sat_r[0] ? SAT_VALUE : root_r[0],
                         sat_r[1] ? SAT_VALUE : root_r[1],
                         sat_r[2] ? SAT_VALUE : root_r[2]};
    end
  end

  assign sts.produce  = produce;
  assign sts.direct   = kind_r || border;
  assign sts.out_free = !out_tvalid || out_tready;
endmodule
`default_nettype wire

FILE: hw/rtl/sobm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sobm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tlast
);
  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");
  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");
  // no result right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
endmodule

bind sobel_edge_magnitude_rgb_unit sobm_checker u_sobm_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
`default_nettype wire
